// ===== hdl/fps_pkg.sv =====
package fps_pkg;

   localparam int TIMER_WIDTH = 32;
   localparam int MS_WIDTH = 16;
   localparam int MASS_WIDTH = 17;
   localparam int CSR_INDEX_WIDTH = 3;

   typedef logic [TIMER_WIDTH-1:0] timer_type;
   typedef logic [MS_WIDTH-1:0] ms_type;
   typedef logic [MASS_WIDTH-1:0] mass_type;
   typedef logic [1:0] op_type;
   typedef logic [1:0] phase_type;
   typedef logic [1:0] err_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   typedef struct packed {
      ms_type hold;
      logic fire;
   } limit_type;

   localparam op_type OP_TICK = 2'd0;
   localparam op_type OP_ARM = 2'd1;
   localparam op_type OP_LAUNCH = 2'd2;

   localparam phase_type PH_PREFLIGHT = 2'd0;
   localparam phase_type PH_ARMED = 2'd1;
   localparam phase_type PH_FLIGHT = 2'd2;
   localparam phase_type PH_RECOVERY = 2'd3;

   localparam err_type ERR_NONE = 2'd0;
   localparam err_type ERR_ARM_UNSAFE = 2'd1;
   localparam err_type ERR_ARM_NOT_PREFLIGHT = 2'd2;
   localparam err_type ERR_LAUNCH_NOT_ARMED = 2'd3;

   localparam csr_index_type CSR_MASS_THRESHOLD = 3'd0;
   localparam csr_index_type CSR_ARM_DWELL = 3'd1;
   localparam csr_index_type CSR_PHASE_DWELL = 3'd2;
   localparam csr_index_type CSR_DEPLOY_DWELL = 3'd3;
   localparam csr_index_type CSR_CHUTE_HOLDOFF = 3'd4;

   localparam mass_type RST_MASS_THRESHOLD = 17'd32768;
   localparam ms_type RST_ARM_DWELL = 16'd250;
   localparam ms_type RST_PHASE_DWELL = 16'd1000;
   localparam ms_type RST_DEPLOY_DWELL = 16'd250;
   localparam ms_type RST_CHUTE_HOLDOFF = 16'd1000;

   // saturating dwell timer, cleared when its condition drops
   function automatic timer_type dwell(timer_type t, ms_type d, logic cond);
      logic [TIMER_WIDTH:0] sum;
      sum = {1'b0, t} + {{(TIMER_WIDTH + 1 - MS_WIDTH){1'b0}}, d};
      if (!cond) begin
         return '0;
      end else if (sum[TIMER_WIDTH]) begin
         return '1;
      end else begin
         return sum[TIMER_WIDTH-1:0];
      end
   endfunction

   // rate limiter of one chute
   function automatic limit_type limiter(ms_type hold, ms_type d, logic want,
                                         ms_type holdoff);
      limit_type r;
      r.hold = '0;
      r.fire = 1'b0;
      if (hold > d) begin
         r.hold = hold - d;
      end else if (want) begin
         r.hold = holdoff;
         r.fire = 1'b1;
      end
      return r;
   endfunction

endpackage

// ===== hdl/flight_phase_sequencer.sv =====
// Channel  Direction  Handshake              Word
// req      in         req_valid / req_stall  operation, delta, three masses
// rsp      out        rsp_valid / rsp_stall  phase, flags, fire pulses, error
// csr      in         csr_valid / csr_ready  register index, write data
//
// One item per cycle while rsp is not stalled. A word accepted on req passes
// through the input register and then the result register to rsp, with the
// sequencer state updated as the result register loads.
// Reset is synchronous, active high; it restores the register defaults,
// preflight and clears all timers. csr_ready is always high.
// A stalled rsp holds the result and the input register; req stalls only
// when both are full.
module flight_phase_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  fps_pkg::op_type        req_operation,
   input  fps_pkg::ms_type        req_delta_ms,
   input  fps_pkg::mass_type      req_ground_mass,
   input  fps_pkg::mass_type      req_drogue_mass,
   input  fps_pkg::mass_type      req_main_mass,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output fps_pkg::phase_type     rsp_phase,
   output logic                   rsp_phase_changed,
   output logic                   rsp_arm_permitted,
   output logic                   rsp_fire_drogue,
   output logic                   rsp_fire_main,
   output logic                   rsp_fire_igniter,
   output fps_pkg::err_type       rsp_error_code,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  fps_pkg::csr_index_type csr_index,
   input  fps_pkg::mass_type      csr_data
);
   import fps_pkg::*;

   mass_type  mass_threshold_ff;
   ms_type    arm_dwell_ff;
   ms_type    phase_dwell_ff;
   ms_type    deploy_dwell_ff;
   ms_type    chute_holdoff_ff;

   logic      s1_valid_ff;
   op_type    s1_operation_ff;
   ms_type    s1_delta_ff;
   mass_type  s1_ground_ff;
   mass_type  s1_drogue_ff;
   mass_type  s1_main_ff;

   phase_type phase_ff, phase_in;
   logic      arm_ok_ff, arm_ok_in;
   timer_type ground_time_ff, ground_time_in;
   timer_type airborne_time_ff, airborne_time_in;
   timer_type drogue_time_ff, drogue_time_in;
   timer_type main_time_ff, main_time_in;
   ms_type    drogue_hold_ff, drogue_hold_in;
   ms_type    main_hold_ff, main_hold_in;

   logic      rsp_valid_ff;
   phase_type rsp_phase_ff;
   logic      rsp_changed_ff;
   logic      rsp_arm_ff;
   logic      rsp_drogue_ff, rsp_drogue_in;
   logic      rsp_main_ff, rsp_main_in;
   logic      rsp_igniter_ff, rsp_igniter_in;
   err_type   rsp_error_ff, rsp_error_in;

   logic      advance;
   logic      process;
   logic      grounded;
   logic      in_flight;
   phase_type mid_phase;
   limit_type drogue_lim;
   limit_type main_lim;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign process = advance && s1_valid_ff;
   assign req_stall = s1_valid_ff && !advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_threshold_ff <= RST_MASS_THRESHOLD;
         arm_dwell_ff <= RST_ARM_DWELL;
         phase_dwell_ff <= RST_PHASE_DWELL;
         deploy_dwell_ff <= RST_DEPLOY_DWELL;
         chute_holdoff_ff <= RST_CHUTE_HOLDOFF;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MASS_THRESHOLD: mass_threshold_ff <= csr_data;
            CSR_ARM_DWELL: arm_dwell_ff <= csr_data[MS_WIDTH-1:0];
            CSR_PHASE_DWELL: phase_dwell_ff <= csr_data[MS_WIDTH-1:0];
            CSR_DEPLOY_DWELL: deploy_dwell_ff <= csr_data[MS_WIDTH-1:0];
            CSR_CHUTE_HOLDOFF: chute_holdoff_ff <= csr_data[MS_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_operation_ff <= req_operation;
         s1_delta_ff <= req_delta_ms;
         s1_ground_ff <= req_ground_mass;
         s1_drogue_ff <= req_drogue_mass;
         s1_main_ff <= req_main_mass;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      arm_ok_in = arm_ok_ff;
      ground_time_in = ground_time_ff;
      airborne_time_in = airborne_time_ff;
      drogue_time_in = drogue_time_ff;
      main_time_in = main_time_ff;
      drogue_hold_in = drogue_hold_ff;
      main_hold_in = main_hold_ff;
      rsp_drogue_in = 1'b0;
      rsp_main_in = 1'b0;
      rsp_igniter_in = 1'b0;
      rsp_error_in = ERR_NONE;
      grounded = s1_ground_ff > mass_threshold_ff;
      in_flight = phase_ff == PH_FLIGHT;
      mid_phase = phase_ff;
      drogue_lim = '0;
      main_lim = '0;
      unique case (s1_operation_ff)
         OP_TICK: begin
            ground_time_in = dwell(ground_time_ff, s1_delta_ff, grounded);
            airborne_time_in = dwell(airborne_time_ff, s1_delta_ff, !grounded);
            drogue_time_in = dwell(drogue_time_ff, s1_delta_ff,
                                   in_flight && (s1_drogue_ff > mass_threshold_ff));
            main_time_in = dwell(main_time_ff, s1_delta_ff,
                                 in_flight && (s1_main_ff > mass_threshold_ff));
            arm_ok_in = ground_time_in > {{(TIMER_WIDTH - MS_WIDTH){1'b0}}, arm_dwell_ff};
            if (airborne_time_in > {{(TIMER_WIDTH - MS_WIDTH){1'b0}}, phase_dwell_ff}
                && !in_flight) begin
               mid_phase = PH_FLIGHT;
            end
            phase_in = mid_phase;
            if (ground_time_in > {{(TIMER_WIDTH - MS_WIDTH){1'b0}}, phase_dwell_ff}
                && mid_phase == PH_FLIGHT) begin
               phase_in = PH_RECOVERY;
            end
            drogue_lim = limiter(drogue_hold_ff, s1_delta_ff,
               drogue_time_in > {{(TIMER_WIDTH - MS_WIDTH){1'b0}}, deploy_dwell_ff},
               chute_holdoff_ff);
            main_lim = limiter(main_hold_ff, s1_delta_ff,
               main_time_in > {{(TIMER_WIDTH - MS_WIDTH){1'b0}}, deploy_dwell_ff},
               chute_holdoff_ff);
            drogue_hold_in = drogue_lim.hold;
            main_hold_in = main_lim.hold;
            rsp_drogue_in = drogue_lim.fire;
            rsp_main_in = main_lim.fire;
         end
         OP_ARM: begin
            if (phase_ff != PH_PREFLIGHT) begin
               rsp_error_in = ERR_ARM_NOT_PREFLIGHT;
            end else if (!arm_ok_ff) begin
               rsp_error_in = ERR_ARM_UNSAFE;
            end else begin
               phase_in = PH_ARMED;
            end
         end
         OP_LAUNCH: begin
            if (phase_ff == PH_ARMED) begin
               rsp_igniter_in = 1'b1;
            end else begin
               rsp_error_in = ERR_LAUNCH_NOT_ARMED;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PREFLIGHT;
         arm_ok_ff <= 1'b0;
         ground_time_ff <= '0;
         airborne_time_ff <= '0;
         drogue_time_ff <= '0;
         main_time_ff <= '0;
         drogue_hold_ff <= '0;
         main_hold_ff <= '0;
      end else if (process) begin
         phase_ff <= phase_in;
         arm_ok_ff <= arm_ok_in;
         ground_time_ff <= ground_time_in;
         airborne_time_ff <= airborne_time_in;
         drogue_time_ff <= drogue_time_in;
         main_time_ff <= main_time_in;
         drogue_hold_ff <= drogue_hold_in;
         main_hold_ff <= main_hold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         rsp_phase_ff <= phase_in;
         rsp_changed_ff <= phase_in != phase_ff;
         rsp_arm_ff <= arm_ok_in;
         rsp_drogue_ff <= rsp_drogue_in;
         rsp_main_ff <= rsp_main_in;
         rsp_igniter_ff <= rsp_igniter_in;
         rsp_error_ff <= rsp_error_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_phase = rsp_phase_ff;
   assign rsp_phase_changed = rsp_changed_ff;
   assign rsp_arm_permitted = rsp_arm_ff;
   assign rsp_fire_drogue = rsp_drogue_ff;
   assign rsp_fire_main = rsp_main_ff;
   assign rsp_fire_igniter = rsp_igniter_ff;
   assign rsp_error_code = rsp_error_ff;

   a_igniter_only_armed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_igniter_ff |-> rsp_phase_ff == PH_ARMED
                                         && rsp_error_ff == ERR_NONE
                                         && !rsp_changed_ff)
      else $error("igniter pulse outside armed phase");

   a_chute_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_drogue_ff || rsp_main_ff) |-> rsp_error_ff == ERR_NONE
                                                          && !rsp_igniter_ff)
      else $error("chute pulse on a command word");

   a_drogue_holdoff_loaded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_drogue_ff |-> drogue_hold_ff == chute_holdoff_ff)
      else $error("drogue holdoff not loaded on fire");

   a_timers_exclusive: assert property (@(posedge clock) disable iff (reset)
      ground_time_ff != '0 |-> airborne_time_ff == '0)
      else $error("ground and airborne dwell both running");

   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(phase_ff) && $stable(ground_time_ff))
      else $error("state moved while result stalled");

endmodule
